/* design/ngfs_pkg.sv */
// shared types and constants for the gravity force accumulator
package ngfs_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ,
        ST_SQRT,
        ST_KMUL,
        ST_DSQ,
        ST_DIV,
        ST_TMUL,
        ST_TDIV,
        ST_ACC,
        ST_OUT
    } t_state;

    localparam logic [2:0] REG_OBJ_X    = 3'd0;
    localparam logic [2:0] REG_OBJ_Y    = 3'd1;
    localparam logic [2:0] REG_OBJ_Z    = 3'd2;
    localparam logic [2:0] REG_OBJ_MASS = 3'd3;
    localparam logic [2:0] REG_GRAV     = 3'd4;
    localparam logic [2:0] REG_MIN_DIST = 3'd5;

    localparam logic [63:0] POS_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

endpackage

/* design/ngfs_div.sv */
// restoring divider, one quotient bit per cycle, 128 by 128 bits
module ngfs_div (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [127:0] i_num,
    input  logic [127:0] i_den,
    output logic         o_done,
    output logic [127:0] o_quo
);
    logic [127:0] r_num, r_den, r_rem;
    logic [7:0]   r_cnt;
    logic         r_busy, r_done;
    logic [128:0] w_sh, w_df;

    assign w_sh = {r_rem, r_num[127]};
    assign w_df = w_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 8'd1;
                if (r_cnt == 8'd127) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            if (!w_df[128]) begin
                r_rem <= w_df[127:0];
                r_num <= {r_num[126:0], 1'b1};
            end else begin
                r_rem <= w_sh[127:0];
                r_num <= {r_num[126:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_num;
endmodule

/* design/nbody_gravity_force_sum_top.sv */
// top level: direct-summation gravity force accumulator
//
//  channel | direction | handshake           | payload
//  src     | in        | i_valid / o_stall   | i_src_x/y/z, i_src_mass, i_last
//  force   | out       | o_valid / i_stall   | o_force_x/y/z, o_saturated
//  cfg     | in        | i_cfg_we            | i_cfg_index, i_cfg_data
//
// a source word keeps the block busy after it is taken; one that is too close to add
// anything skips the division steps; a word marked last adds an emit step
// every product runs on one shared 32x32 multiplier: 3 squares, a 35-step
// square root, G*M*m and d^2; one 128-step division for the magnitude,
// then per axis a product, a 128-step division and an accumulate
// reset clears the sums, the flag and the registers to their reset values
// a force word waits in the output register; new words are taken meanwhile and the
// block only holds in the emit step while the previous force word is still stalled
module nbody_gravity_force_sum_top import ngfs_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [31:0] i_src_x,
    input  logic signed [31:0] i_src_y,
    input  logic signed [31:0] i_src_z,
    input  logic [31:0]        i_src_mass,
    input  logic               i_last,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [63:0] o_force_x,
    output logic signed [63:0] o_force_y,
    output logic signed [63:0] o_force_z,
    output logic               o_saturated,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);
    // config registers
    logic signed [31:0] r_obj_x, r_obj_y, r_obj_z;
    logic [31:0]        r_obj_m, r_grav, r_min_d;

    t_state r_st, n_st;

    // per-word working registers
    logic [32:0]  r_ad [3];      // |dx|, |dy|, |dz|
    logic         r_pos [3];     // component difference positive
    logic [31:0]  r_msrc;
    logic         r_last;
    logic [65:0]  r_s;
    logic [34:0]  r_d;
    logic [5:0]   r_cnt;
    logic [1:0]   r_ax;
    logic [127:0] r_k, r_t;
    logic [63:0]  r_mag;
    logic [63:0]  r_term [3];
    logic signed [63:0] r_sum [3];
    logic         r_sat;
    logic         r_ov;
    logic [1:0]   r_sub;         // which of the two products of G*M*m
    logic         r_outv;

    // shared multiplier: 64x64 operands picked by the sequencer, built up from
    // one 32x32 partial product per cycle
    logic [63:0]  w_ma, w_mb;
    logic [1:0]   r_mph;         // partial product phase
    logic [127:0] r_macc;
    logic [31:0]  w_asel, w_bsel;
    logic [63:0]  w_pp;
    logic [127:0] w_ppsh, w_mp;
    logic         w_mul_on, w_mfin;

    assign w_asel = r_mph[1] ? w_ma[63:32] : w_ma[31:0];
    assign w_bsel = r_mph[0] ? w_mb[63:32] : w_mb[31:0];
    // 32x32 partial product
    assign w_pp   = 64'(w_asel) * 64'(w_bsel);

    always_comb begin
        case (r_mph)
            2'd0:    w_ppsh = {64'd0, w_pp};
            2'd3:    w_ppsh = {w_pp, 64'd0};
            default: w_ppsh = {32'd0, w_pp, 32'd0};
        endcase
    end

    // full product, valid in the last phase
    assign w_mp     = r_macc + w_ppsh;
    assign w_mul_on = r_st inside {ST_SQ, ST_SQRT, ST_KMUL, ST_DSQ, ST_TMUL};
    assign w_mfin   = w_mul_on && (r_mph == 2'd3);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mph  <= '0;
            r_macc <= '0;
        end else if (w_mul_on && !w_mfin) begin
            r_mph  <= r_mph + 2'd1;
            r_macc <= w_mp;
        end else begin
            r_mph  <= '0;
            r_macc <= '0;
        end
    end

    logic         w_dstart;
    logic [127:0] w_dnum, w_dden, w_quo;
    logic         w_ddone;

    ngfs_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(w_dstart),
        .i_num  (w_dnum),
        .i_den  (w_dden),
        .o_done (w_ddone),
        .o_quo  (w_quo)
    );

    logic [34:0] w_cand;
    assign w_cand = r_d | (35'd1 << r_cnt);

    always_comb begin
        w_ma = '0;
        w_mb = '0;
        unique case (r_st)
            ST_SQ:   begin w_ma = 64'(r_ad[r_ax]); w_mb = 64'(r_ad[r_ax]); end
            ST_SQRT: begin w_ma = 64'(w_cand);    w_mb = 64'(w_cand);    end
            ST_KMUL: begin
                if (r_sub == 2'd0) begin
                    w_ma = 64'(r_grav); w_mb = 64'(r_msrc);
                end else begin
                    w_ma = r_k[63:0];   w_mb = 64'(r_obj_m);
                end
            end
            ST_DSQ:  begin w_ma = 64'(r_d); w_mb = 64'(r_d); end
            ST_TMUL: begin w_ma = 64'(r_ad[r_ax]); w_mb = r_mag; end
            default: ;
        endcase
    end

    logic w_acc_en;
    assign w_acc_en = (r_d != '0) && (r_d >= 35'(r_min_d));

    // emit step: output register free or its word taken at this edge
    logic w_emit;
    assign w_emit = (r_st == ST_OUT) && (!r_outv || !i_stall);

    logic signed [64:0] w_tsg, w_nsum;
    assign w_tsg  = r_pos[r_ax] ? -$signed({1'b0, r_term[r_ax]})
                                : $signed({1'b0, r_term[r_ax]});
    assign w_nsum = $signed({r_sum[r_ax][63], r_sum[r_ax]}) + w_tsg;

    always_comb begin
        n_st     = r_st;
        w_dstart = 1'b0;
        w_dnum   = '0;
        w_dden   = '0;
        unique case (r_st)
            ST_IDLE: if (i_valid) n_st = ST_SQ;
            ST_SQ:   if (w_mfin && r_ax == 2'd2) n_st = ST_SQRT;
            ST_SQRT: if (w_mfin && r_cnt == '0) n_st = ST_KMUL;
            ST_KMUL: if (w_mfin && r_sub == 2'd1) n_st = ST_DSQ;
            ST_DSQ: begin
                if (w_mfin) begin
                    if (!w_acc_en) n_st = r_last ? ST_OUT : ST_IDLE;
                    else begin
                        n_st     = ST_DIV;
                        w_dstart = 1'b1;
                        w_dnum   = r_k;
                        w_dden   = w_mp;
                    end
                end
            end
            ST_DIV:  if (w_ddone) n_st = ST_TMUL;
            ST_TMUL: begin
                if (w_mfin) begin
                    n_st     = ST_TDIV;
                    w_dstart = 1'b1;
                    w_dnum   = w_mp;
                    w_dden   = 128'(r_d);
                end
            end
            ST_TDIV: if (w_ddone) n_st = ST_ACC;
            ST_ACC:  n_st = (r_ax == 2'd2) ? (r_last ? ST_OUT : ST_IDLE) : ST_TMUL;
            ST_OUT:  if (w_emit) n_st = ST_IDLE;
            default: n_st = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_st <= ST_IDLE;
        else          r_st <= n_st;
    end

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_obj_x <= '0; r_obj_y <= '0; r_obj_z <= '0;
            r_obj_m <= '0; r_grav <= 32'd65536; r_min_d <= 32'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_OBJ_X:    r_obj_x <= i_cfg_data;
                REG_OBJ_Y:    r_obj_y <= i_cfg_data;
                REG_OBJ_Z:    r_obj_z <= i_cfg_data;
                REG_OBJ_MASS: r_obj_m <= i_cfg_data;
                REG_GRAV:     r_grav  <= i_cfg_data;
                REG_MIN_DIST: r_min_d <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic signed [32:0] w_dv [3];
    assign w_dv[0] = 33'(r_obj_x) - 33'(i_src_x);
    assign w_dv[1] = 33'(r_obj_y) - 33'(i_src_y);
    assign w_dv[2] = 33'(r_obj_z) - 33'(i_src_z);

    // datapath and sums
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum[0] <= '0; r_sum[1] <= '0; r_sum[2] <= '0;
            r_sat    <= 1'b0;
            r_outv   <= 1'b0;
        end else begin
            if (w_emit)                 r_outv <= 1'b1;
            else if (r_outv && !i_stall) r_outv <= 1'b0;
            unique case (r_st)
                ST_DIV: if (w_ddone && w_quo[127:64] != '0) r_sat <= 1'b1;
                ST_ACC: begin
                    if (w_nsum > 65'sh0_7FFF_FFFF_FFFF_FFFF) begin
                        r_sum[r_ax] <= 64'sh7FFF_FFFF_FFFF_FFFF;
                        r_sat <= 1'b1;
                    end else if (w_nsum < -65'sh0_8000_0000_0000_0000) begin
                        r_sum[r_ax] <= 64'sh8000_0000_0000_0000;
                        r_sat <= 1'b1;
                    end else begin
                        r_sum[r_ax] <= w_nsum[63:0];
                        if (r_ov) r_sat <= 1'b1;
                    end
                end
                ST_OUT: begin
                    if (w_emit) begin
                        o_force_x   <= r_sum[0];
                        o_force_y   <= r_sum[1];
                        o_force_z   <= r_sum[2];
                        o_saturated <= r_sat;
                        r_sum[0] <= '0; r_sum[1] <= '0; r_sum[2] <= '0;
                        r_sat <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_st)
            ST_IDLE: begin
                for (int i = 0; i < 3; i++) begin
                    r_ad[i]  <= w_dv[i][32] ? 33'(-w_dv[i]) : 33'(w_dv[i]);
                    r_pos[i] <= !w_dv[i][32] && (w_dv[i] != '0);
                end
                r_msrc <= i_src_mass;
                r_last <= i_last;
                r_ax   <= '0;
                r_s    <= '0;
            end
            ST_SQ: begin
                if (w_mfin) begin
                    r_s  <= r_s + w_mp[65:0];
                    r_ax <= r_ax + 2'd1;
                end
                r_cnt <= 6'd34;
                r_d   <= '0;
            end
            ST_SQRT: begin
                if (w_mfin) begin
                    if (w_mp[69:0] <= 70'(r_s)) r_d <= w_cand;
                    r_cnt <= r_cnt - 6'd1;
                end
                r_sub <= '0;
            end
            ST_KMUL: if (w_mfin) begin
                r_sub <= r_sub + 2'd1;
                if (r_sub == 2'd0) r_k <= w_mp;
                else               r_k <= {w_mp[111:0], 16'd0};
            end
            ST_DSQ: r_ax <= '0;
            ST_DIV: if (w_ddone)
                r_mag <= (w_quo[127:64] != '0) ? '1 : w_quo[63:0];
            ST_TDIV: if (w_ddone) begin
                r_ov <= (w_quo[127:63] != '0);
                r_term[r_ax] <= (w_quo[127:63] != '0) ? POS_MAX : w_quo[63:0];
            end
            ST_ACC: r_ax <= r_ax + 2'd1;
            default: ;
        endcase
    end

    assign o_stall = (r_st != ST_IDLE);
    assign o_valid = r_outv;

`ifndef SYNTH
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st != ST_IDLE) |-> o_stall) else $error("accepted while busy");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_force_x)))
        else $error("result dropped under stall");
    a_out_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |=> (r_sum[0] == '0 && !r_sat))
        else $error("sum not cleared on emit");
`endif
endmodule
